// ----- design/tph_pkg.sv -----
// Shared constants, types and helpers for the timer pool.
package tph_pkg;

  // Pool geometry.
  localparam int TIMER_SLOTS = 16;
  localparam int IDENT_BITS  = 16;
  localparam int STEP_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  // Port widths fixed by the command interface.
  localparam int CMD_W    = 3;
  localparam int PORT_ID_W = 16;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 2;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_CANCEL = 3'd1,
    CMD_SET    = 3'd2,
    CMD_QUERY  = 3'd3,
    CMD_TICK   = 3'd4
  } cmd_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_EXPIRED   = 2'd3
  } status_t;

  // Contents of one timer slot.
  typedef struct packed {
    logic                     live;
    logic [IDENT_BITS-1:0]    ident;
    logic signed [TIME_W-1:0] remaining;
  } slot_t;

  // What the slot operator reports for the slot at the head of the ring.
  typedef struct packed {
    slot_t slot_out;
    logic  claim;
    logic  expire;
  } op_t;

  // Low bits of an identifier as shown on the result port.
  function automatic logic [PORT_ID_W-1:0] ident_to_port(input logic [IDENT_BITS-1:0] ident);
    logic [31:0] wide;
    wide = 32'(ident);
    return wide[PORT_ID_W-1:0];
  endfunction

  // Full identifier compared with the zero-extended port identifier.
  function automatic logic ident_match(input logic [IDENT_BITS-1:0] ident,
                                       input logic [PORT_ID_W-1:0] port_id);
    return 32'(ident) == 32'(port_id);
  endfunction

endpackage

// ----- design/tph_cell.sv -----
// One storage cell of the slot ring: holds a timer and takes its neighbor's contents on a shift.
module tph_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  tph_pkg::slot_t d,
  output tph_pkg::slot_t q
);
  import tph_pkg::*;

  slot_t slot_r;

  // Live bit is cleared by reset; identifier and time are undefined until written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.live <= 1'b0;
    end else if (shift_en) begin
      slot_r <= d;
    end
  end

  assign q = slot_r;

endmodule

// ----- design/tph_slot_op.sv -----
// Applies the current command to the slot passing the head of the ring.
module tph_slot_op (
  input  tph_pkg::cmd_t                   cmd,
  input  logic [tph_pkg::PORT_ID_W-1:0]   timer_id,
  input  logic signed [tph_pkg::TIME_W-1:0] time_value,
  input  logic [tph_pkg::IDENT_BITS-1:0]  next_ident,
  input  logic                            found,
  input  tph_pkg::slot_t                  slot_in,
  output tph_pkg::op_t                    op
);
  import tph_pkg::*;

  logic signed [TIME_W:0]   diff;
  logic signed [TIME_W-1:0] sat;
  logic                     match;

  // Exact remaining-minus-delta, saturated to the signed 32-bit range.
  always_comb begin
    diff = {slot_in.remaining[TIME_W-1], slot_in.remaining}
         - {time_value[TIME_W-1], time_value};
    if (diff[TIME_W] != diff[TIME_W-1]) begin
      sat = diff[TIME_W] ? {1'b1, {(TIME_W-1){1'b0}}} : {1'b0, {(TIME_W-1){1'b1}}};
    end else begin
      sat = diff[TIME_W-1:0];
    end
  end

  // First live slot whose identifier matches, before any earlier claim.
  assign match = !found && slot_in.live && ident_match(slot_in.ident, timer_id);

  // Per-command slot update.
  always_comb begin
    op.slot_out = slot_in;
    op.claim    = 1'b0;
    op.expire   = 1'b0;
    unique case (cmd)
      CMD_ADD: begin
        if (!found && !slot_in.live) begin
          op.slot_out.live      = 1'b1;
          op.slot_out.ident     = next_ident;
          op.slot_out.remaining = time_value;
          op.claim              = 1'b1;
        end
      end
      CMD_CANCEL: begin
        if (match) begin
          op.slot_out.live = 1'b0;
          op.claim         = 1'b1;
        end
      end
      CMD_SET: begin
        if (match) begin
          op.slot_out.remaining = time_value;
          op.claim              = 1'b1;
        end
      end
      CMD_QUERY: begin
        op.claim = match;
      end
      CMD_TICK: begin
        if (slot_in.live) begin
          op.slot_out.remaining = sat;
          if (sat[TIME_W-1]) begin
            op.slot_out.live = 1'b0;
            op.expire        = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- design/timer_pool_with_handles.sv -----
// Top level of the timer pool: command sequencer around a rotating ring of slot cells.
//
// Usage: present a command on in_command, in_timer_id and in_time_value with start
// high; the transaction is taken at the edge where start is high and busy is low.
// The sixteen slots sit in a ring of cells that rotates by one place each cycle
// while the sequencer walks it; the slot at the head passes through the slot
// operator, so one full turn visits every slot in slot order and returns the ring
// to its original arrangement. A final state then issues the final result, and busy
// stays high through the walk and that final state. The final result is shown in the
// first cycle with busy low, and the next command is taken at the end of that cycle
// at the earliest, so no command is taken before the last one's final result.
// Results appear for one cycle each with out_valid high and cannot be held off.
// Add, cancel, set time and query give one result, in the first cycle with busy low.
// Tick gives one expiry result per expired timer, each issued during the turn
// when the following expiry is seen, the final one (out_last high) after the
// turn; with no expiry it gives one ok result. Unknown commands give none.
// Reset clears all live bits, the identifier counter and the sequencer at once.
module timer_pool_with_handles (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [tph_pkg::CMD_W-1:0]           in_command,
  input  logic [tph_pkg::PORT_ID_W-1:0]       in_timer_id,
  input  logic signed [tph_pkg::TIME_W-1:0]   in_time_value,
  output logic                                out_valid,
  output logic [tph_pkg::STATUS_W-1:0]        out_status,
  output logic [tph_pkg::PORT_ID_W-1:0]       out_timer_id_res,
  output logic signed [tph_pkg::TIME_W-1:0]   out_time_left,
  output logic                                out_last
);
  import tph_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t                   state_r, state_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  cmd_t                     cmd_r, cmd_nxt;
  logic [PORT_ID_W-1:0]     id_r, id_nxt;
  logic signed [TIME_W-1:0] tv_r, tv_nxt;
  logic                     found_r, found_nxt;
  logic signed [TIME_W-1:0] qtime_r, qtime_nxt;
  logic                     pend_valid_r, pend_valid_nxt;
  logic [IDENT_BITS-1:0]    pend_ident_r, pend_ident_nxt;
  logic [IDENT_BITS-1:0]    next_ident_r, next_ident_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]      out_status_r, out_status_nxt;
  logic [PORT_ID_W-1:0]     out_id_r, out_id_nxt;
  logic signed [TIME_W-1:0] out_time_r, out_time_nxt;
  logic                     out_last_r, out_last_nxt;

  slot_t cell_d [TIMER_SLOTS];
  slot_t cell_q [TIMER_SLOTS];
  op_t   op;
  logic  walking;
  logic  accept;

  assign accept  = start && (state_r == ST_IDLE);
  assign walking = (state_r == ST_WALK);

  // Ring of slot cells; the head cell feeds the operator, whose output enters the tail.
  generate
    for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
      if (i == TIMER_SLOTS - 1) begin : g_tail
        assign cell_d[i] = op.slot_out;
      end else begin : g_body
        assign cell_d[i] = cell_q[i+1];
      end
      tph_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (walking),
        .d        (cell_d[i]),
        .q        (cell_q[i])
      );
    end
  endgenerate

  // Command applied to the slot at the head of the ring.
  tph_slot_op u_op (
    .cmd        (cmd_r),
    .timer_id   (id_r),
    .time_value (tv_r),
    .next_ident (next_ident_r),
    .found      (found_r),
    .slot_in    (cell_q[0]),
    .op         (op)
  );

  // Sequencer and result generation.
  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    cmd_nxt        = cmd_r;
    id_nxt         = id_r;
    tv_nxt         = tv_r;
    found_nxt      = found_r;
    qtime_nxt      = qtime_r;
    pend_valid_nxt = pend_valid_r;
    pend_ident_nxt = pend_ident_r;
    next_ident_nxt = next_ident_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_time_nxt   = out_time_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt        = cmd_t'(in_command);
          id_nxt         = in_timer_id;
          tv_nxt         = in_time_value;
          found_nxt      = 1'b0;
          pend_valid_nxt = 1'b0;
          step_nxt       = '0;
          state_nxt      = ST_WALK;
        end
      end
      ST_WALK: begin
        if (op.claim) begin
          found_nxt = 1'b1;
          qtime_nxt = cell_q[0].remaining;
        end
        // A new expiry releases the one held back, which is then known not to be last.
        if (op.expire) begin
          if (pend_valid_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_EXPIRED;
            out_id_nxt     = ident_to_port(pend_ident_r);
            out_time_nxt   = '0;
            out_last_nxt   = 1'b0;
          end
          pend_valid_nxt = 1'b1;
          pend_ident_nxt = cell_q[0].ident;
        end
        if (step_r == STEP_W'(TIMER_SLOTS - 1)) begin
          state_nxt = ST_FIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_FIN: begin
        state_nxt     = ST_IDLE;
        out_id_nxt    = '0;
        out_time_nxt  = '0;
        out_last_nxt  = 1'b1;
        out_valid_nxt = 1'b1;
        unique case (cmd_r) inside
          CMD_ADD: begin
            if (found_r) begin
              out_status_nxt = STAT_OK;
              out_id_nxt     = ident_to_port(next_ident_r);
              next_ident_nxt = next_ident_r + 1'b1;
            end else begin
              out_status_nxt = STAT_FULL;
            end
          end
          CMD_CANCEL, CMD_SET: begin
            out_status_nxt = found_r ? STAT_OK : STAT_NOT_FOUND;
          end
          CMD_QUERY: begin
            out_status_nxt = found_r ? STAT_OK : STAT_NOT_FOUND;
            out_time_nxt   = found_r ? qtime_r : '0;
          end
          CMD_TICK: begin
            if (pend_valid_r) begin
              out_status_nxt = STAT_EXPIRED;
              out_id_nxt     = ident_to_port(pend_ident_r);
            end else begin
              out_status_nxt = STAT_OK;
            end
          end
          default: begin
            out_valid_nxt = 1'b0;
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers are reset; payload registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      next_ident_r <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      found_r      <= 1'b0;
      step_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      next_ident_r <= next_ident_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      found_r      <= found_nxt;
      step_r       <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    id_r         <= id_nxt;
    tv_r         <= tv_nxt;
    qtime_r      <= qtime_nxt;
    pend_ident_r <= pend_ident_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_time_r   <= out_time_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_timer_id_res = out_id_r;
  assign out_time_left    = out_time_r;
  assign out_last         = out_last_r;

endmodule

// ----- design/tph_checker.sv -----
// Port-level checks on the timer pool, bound to the top level.
module tph_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic [tph_pkg::STATUS_W-1:0]      out_status,
  input logic [tph_pkg::PORT_ID_W-1:0]     out_timer_id_res,
  input logic [tph_pkg::TIME_W-1:0]        out_time_left,
  input logic                              out_last
);
  import tph_pkg::*;

  // An accepted transaction keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted command");

  // Only expiry results may be followed by more results of the same command.
  a_not_last_expiry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_status == STAT_EXPIRED))
    else $error("non-final result that is not an expiry");

  // A nonzero remaining time is only reported with an ok status.
  a_time_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_time_left != '0)) |-> (out_status == STAT_OK))
    else $error("time_left nonzero on a result that is not ok");

  // The final result of a command is followed by a quiet cycle.
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("result issued right after a final result");

  // Full and not-found results carry no identifier.
  a_err_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_status == STAT_FULL) || (out_status == STAT_NOT_FOUND)))
      |-> (out_timer_id_res == '0))
    else $error("error result carries an identifier");

endmodule

bind timer_pool_with_handles tph_checker u_tph_checker (.*);
